// ===== rtl/salc_pkg.sv =====
`default_nettype none
package salc_pkg;
    // Access kinds.
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_STORE = 2'd1;
    localparam logic [1:0] CMD_FETCH = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_SPLIT = 3'd0;
    localparam logic [2:0] REG_ISETS = 3'd1;
    localparam logic [2:0] REG_DSETS = 3'd2;
    localparam logic [2:0] REG_BLOCK = 3'd3;
    localparam logic [2:0] REG_WAYS  = 3'd4;
    localparam logic [2:0] REG_WB    = 3'd5;
    localparam logic [2:0] REG_WA    = 3'd6;

    // Sequencer states.
    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_LOOK  = 2'd2;
endpackage
`default_nettype wire

// ===== rtl/salc_ram.sv =====
`default_nettype none
module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/set_assoc_lru_cache_model_top.sv =====
`default_nettype none
// Set-associative cache model with true LRU replacement.
// Command channel: pulse start with i_cmd and i_address while busy is
// low; the word is taken at that edge. Exactly one result word follows
// the lookup state, registered and shown for one cycle with o_done high;
// the receiver cannot stall it. A new access may start in the cycle the
// result shows; busy stays high during the lookup, since each access
// reads then writes one set row in the state memory.
// The state memory holds one row per set (both banks): per way a tag,
// valid, dirty and age. After reset, and after every configuration write,
// a clearing pass writes each row invalid, one row a cycle, over all
// 2*2^MAX_SET_BITS rows (2048 at default sizes) with busy high.
// Configuration writes use i_cfg_we, i_cfg_index and i_cfg_data and take
// effect at once; write only while idle.
module set_assoc_lru_cache_model_top
    import salc_pkg::*;
#(
    parameter int MAX_SET_BITS = 10,
    parameter int MAX_WAYS     = 8,
    parameter int ADDR_BITS    = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [1:0]           i_cmd,
    input  wire logic [ADDR_BITS-1:0] i_address,
    input  wire logic                 i_cfg_we,
    input  wire logic [2:0]           i_cfg_index,
    input  wire logic [3:0]           i_cfg_data,
    output logic                      o_done,
    output logic                      o_hit,
    output logic                      o_data_side,
    output logic                      o_replaced,
    output logic [6:0]                o_fetch_words,
    output logic [6:0]                o_copy_back_words
);
    localparam int TAGW  = ADDR_BITS - 2;
    localparam int WAYB  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int AGEW  = 3;
    localparam int LINEW = TAGW + 2 + AGEW;
    localparam int ROWW  = LINEW * MAX_WAYS;
    localparam int ROWS  = 2 << MAX_SET_BITS;
    localparam int RB    = MAX_SET_BITS + 1;

    // Configuration registers.
    logic       r_split, r_wb, r_wa;
    logic [3:0] r_isb, r_dsb, r_bb, r_ways;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_split <= 1'b0; r_isb <= 4'd9; r_dsb <= 4'd9; r_bb <= 4'd4;
            r_ways <= 4'd1; r_wb <= 1'b1; r_wa <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SPLIT: r_split <= i_cfg_data[0];
                REG_ISETS: r_isb   <= i_cfg_data;
                REG_DSETS: r_dsb   <= i_cfg_data;
                REG_BLOCK: r_bb    <= i_cfg_data;
                REG_WAYS:  r_ways  <= i_cfg_data;
                REG_WB:    r_wb    <= i_cfg_data[0];
                REG_WA:    r_wa    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end
    wire cfg_hit = i_cfg_we && (i_cfg_index inside {[REG_SPLIT:REG_WA]});

    // Effective sizes after saturation.
    logic [3:0] bb, nw;
    always_comb begin
        bb = (r_bb < 4'd2) ? 4'd2 : ((r_bb > 4'd8) ? 4'd8 : r_bb);
        nw = (r_ways == 4'd0) ? 4'd1 :
             ((32'(r_ways) > MAX_WAYS) ? 4'(MAX_WAYS) : r_ways);
    end
    wire [6:0] words = 7'((9'd1 << bb) >> 2);

    // Address split for the incoming access.
    logic        in_side, in_bank;
    logic [3:0]  sb;
    logic [ADDR_BITS-1:0] blk;
    logic [RB-1:0] in_row;
    always_comb begin
        in_side = (i_cmd != CMD_FETCH);
        in_bank = r_split && in_side;
        sb = in_bank ? r_dsb : r_isb;
        if (32'(sb) > MAX_SET_BITS) sb = 4'(MAX_SET_BITS);
        blk = i_address >> bb;
        in_row = {in_bank,
                  MAX_SET_BITS'(blk & ((ADDR_BITS'(1) << sb) - ADDR_BITS'(1)))};
    end

    // Sequencer and per-access registers.
    logic [1:0]    r_state;
    logic [RB-1:0] r_row, r_clr;
    logic [TAGW-1:0] r_tag;
    logic          r_store, r_side;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr <= '0;
        end else if (cfg_hit) begin
            r_state <= ST_CLEAR;
            r_clr <= '0;
        end else begin
            case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == RB'(ROWS - 1)) r_state <= ST_IDLE;
                end
                ST_IDLE: if (start) r_state <= ST_LOOK;
                ST_LOOK: r_state <= ST_IDLE;
                default: r_state <= ST_CLEAR;
            endcase
        end
    end
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && start) begin
            r_row   <= in_row;
            r_tag   <= TAGW'((blk >> sb));
            r_store <= (i_cmd == CMD_STORE);
            r_side  <= in_side;
        end
    end
    assign busy = (r_state != ST_IDLE);

    // Row memory.
    logic            we;
    logic [RB-1:0]   waddr;
    logic [ROWW-1:0] wdata, rdata;
    salc_ram #(.WIDTH(ROWW), .DEPTH(ROWS)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(in_row), .o_rdata(rdata)
    );

    // Lookup, victim choice and row update.
    logic [TAGW-1:0] tg [MAX_WAYS];
    logic [MAX_WAYS-1:0] vl, dt;
    logic [AGEW-1:0] ag [MAX_WAYS];
    logic [MAX_WAYS-1:0] act;
    logic [WAYB-1:0] hw, vw;
    logic hit, found, inv, full, alloc;
    logic [AGEW-1:0] best, old;
    logic [6:0] fetch, copy;
    logic [ROWW-1:0] nrow;
    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            tg[w] = rdata[w*LINEW +: TAGW];
            vl[w] = rdata[w*LINEW + TAGW];
            dt[w] = rdata[w*LINEW + TAGW + 1];
            ag[w] = rdata[w*LINEW + TAGW + 2 +: AGEW];
            act[w] = (w < 32'(nw)) && vl[w];
        end
        hit = 1'b0; hw = '0; inv = 1'b0; vw = '0; found = 1'b0; best = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (!hit && act[w] && tg[w] == r_tag) begin
                hit = 1'b1; hw = WAYB'(w);
            end
            if (!inv && (w < 32'(nw)) && !vl[w]) begin
                inv = 1'b1;
                if (!found) vw = WAYB'(w);
            end
        end
        full = !inv;
        if (full) begin
            for (int w = 0; w < MAX_WAYS; w++) begin
                if (act[w] && (!found || ag[w] > best)) begin
                    found = 1'b1; vw = WAYB'(w); best = ag[w];
                end
            end
        end
        old = ag[hw];
        alloc = !hit && !(r_store && !r_wa);
        fetch = alloc ? words : 7'd0;
        copy = 7'd0;
        if (hit && r_store && !r_wb) copy = 7'd1;
        if (!hit && !alloc) copy = 7'd1;
        if (alloc) begin
            if (full && dt[vw] && r_wb) copy = words;
            if (r_store && !r_wb) copy = copy + 7'd1;
        end
        nrow = rdata;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (hit && act[w] && ag[w] < old)
                nrow[w*LINEW + TAGW + 2 +: AGEW] = ag[w] + 1'b1;
            if (alloc && act[w] && ag[w] != 3'd7)
                nrow[w*LINEW + TAGW + 2 +: AGEW] = ag[w] + 1'b1;
        end
        if (hit) begin
            nrow[32'(hw)*LINEW + TAGW + 2 +: AGEW] = '0;
            if (r_store && r_wb) nrow[32'(hw)*LINEW + TAGW + 1] = 1'b1;
        end
        if (alloc) begin
            nrow[32'(vw)*LINEW +: LINEW] = {AGEW'(0), r_store && r_wb, 1'b1, r_tag};
        end
    end

    always_comb begin
        we = 1'b0; waddr = r_row; wdata = nrow;
        if (r_state == ST_CLEAR) begin
            we = 1'b1; waddr = r_clr; wdata = '0;
        end else if (r_state == ST_LOOK) begin
            we = 1'b1;
        end
    end

    // Result word register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_done <= 1'b0;
        else o_done <= (r_state == ST_LOOK) && !cfg_hit;
    end
    always_ff @(posedge i_clk) begin
        if (r_state == ST_LOOK) begin
            o_hit <= hit; o_data_side <= r_side;
            o_replaced <= alloc && full;
            o_fetch_words <= fetch; o_copy_back_words <= copy;
        end
    end
endmodule
`default_nettype wire
